// File: src/modexp_pkg.sv
// Shared types and constants for the modular exponentiation block.
// No dependencies.
`default_nettype none
package modexp_pkg;
  localparam int WIDTH = 32;
  localparam int CNT_W = $clog2(WIDTH + 1);

  typedef logic [WIDTH-1:0] word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture base, exponent, modulus
    logic reduce;     // one step of operand reduction (x mod m)
    logic mul_start;  // start a modular multiplication
    logic mul_sel;    // 1: acc*sq into acc, 0: sq*sq into sq
    logic mul_step;   // one bit step of the multiplication
    logic mul_done;   // write the product back
    logic shift_e;    // drop the exponent LSB
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic e_zero;
    logic e_lsb;
    logic last_bit;   // multiplication bit counter at its final step
    logic red_done;   // operand reduction finished
  } dp_stat_t;
endpackage
`default_nettype wire

// File: src/modexp_datapath.sv
// Datapath: operand registers, bit-serial modular multiplier, reduction.
// Depends on modexp_pkg.
`default_nettype none
module modexp_datapath (
  input  wire logic                clk,
  input  wire modexp_pkg::dp_cmd_t cmd,
  input  wire modexp_pkg::word_t   base_in,
  input  wire modexp_pkg::word_t   exp_in,
  input  wire modexp_pkg::word_t   mod_in,
  output modexp_pkg::dp_stat_t     stat,
  output modexp_pkg::word_t        acc_out
);
  localparam int W = modexp_pkg::WIDTH;

  modexp_pkg::word_t m, sq, e, acc, r, x, y;
  logic [modexp_pkg::CNT_W-1:0] bitcnt;
  // Destination of the running product, latched when it starts.
  logic mul_dst;
  // Reduction of base below m: restoring division, one bit a step.
  modexp_pkg::word_t rem;
  modexp_pkg::word_t quo;
  logic [modexp_pkg::CNT_W-1:0] redcnt;

  // Modular add helper: (a + b) mod m for a, b < m.
  function automatic modexp_pkg::word_t add_mod(modexp_pkg::word_t a,
      modexp_pkg::word_t b, modexp_pkg::word_t md);
    logic [W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (md == '0) return s[W-1:0];
    if (s >= {1'b0, md}) s = s - {1'b0, md};
    return s[W-1:0];
  endfunction

  modexp_pkg::word_t r2, r2x;
  assign r2  = add_mod(r, r, m);
  assign r2x = add_mod(r2, x, m);

  logic [W:0] rem_sh;
  assign rem_sh = {rem, quo[W-1]};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      m <= mod_in;
      e <= exp_in;
      acc <= modexp_pkg::word_t'(1);
      rem <= '0;
      quo <= base_in;
      redcnt <= '0;
    end
    if (cmd.reduce) begin
      if (rem_sh >= {1'b0, m}) rem <= W'(rem_sh - {1'b0, m});
      else rem <= rem_sh[W-1:0];
      quo <= {quo[W-2:0], 1'b0};
      redcnt <= redcnt + 1'b1;
      if (redcnt == modexp_pkg::CNT_W'(W - 1)) begin
        if (rem_sh >= {1'b0, m}) sq <= W'(rem_sh - {1'b0, m});
        else sq <= rem_sh[W-1:0];
      end
    end
    if (cmd.mul_start) begin
      r <= '0;
      bitcnt <= '0;
      x <= cmd.mul_sel ? acc : sq;
      y <= sq;
      mul_dst <= cmd.mul_sel;
    end
    if (cmd.mul_step) begin
      if (m == '0) r <= (r << 1) + (y[W-1] ? x : '0);
      else r <= y[W-1] ? r2x : r2;
      y <= {y[W-2:0], 1'b0};
      bitcnt <= bitcnt + 1'b1;
    end
    if (cmd.mul_done) begin
      if (mul_dst) acc <= r;
      else sq <= r;
    end
    if (cmd.shift_e) e <= e >> 1;
  end

  always_comb begin
    stat.e_zero   = (e == '0);
    stat.e_lsb    = e[0];
    stat.last_bit = (bitcnt == modexp_pkg::CNT_W'(W - 1));
    stat.red_done = (redcnt == modexp_pkg::CNT_W'(W - 1));
  end
  assign acc_out = acc;
endmodule
`default_nettype wire

// File: src/modexp_ctrl.sv
// Controller state machine sequencing reduction and multiplications.
// Depends on modexp_pkg.
`default_nettype none
module modexp_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  input  wire modexp_pkg::dp_stat_t stat,
  output modexp_pkg::dp_cmd_t       cmd
);
  localparam logic [2:0] S_IDLE = 3'd0, S_RED = 3'd1, S_CHK = 3'd2,
                         S_MUL = 3'd3, S_WB = 3'd4, S_OUT = 3'd5;
  logic [2:0] state, state_next;
  logic sel, sel_next;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next = state;
    sel_next = sel;
    cmd = '0;
    cmd.mul_sel = sel;
    unique case (state)
      S_IDLE: if (in_valid) begin
        cmd.load = 1'b1;
        state_next = S_RED;
      end
      S_RED: begin
        cmd.reduce = 1'b1;
        if (stat.red_done) state_next = S_CHK;
      end
      S_CHK: begin
        if (stat.e_zero) state_next = S_OUT;
        else begin
          sel_next = stat.e_lsb;
          cmd.mul_sel = stat.e_lsb;
          cmd.mul_start = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        if (stat.last_bit) state_next = S_WB;
      end
      S_WB: begin
        cmd.mul_done = 1'b1;
        if (sel) begin
          sel_next = 1'b0;
          cmd.mul_start = 1'b1;
          cmd.mul_sel = 1'b0;
          state_next = S_MUL;
        end else begin
          cmd.shift_e = 1'b1;
          state_next = S_CHK;
        end
      end
      S_OUT: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sel <= 1'b0;
    end else begin
      state <= state_next;
      sel <= sel_next;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("ready while result pending");
  a_wb: assert property (@(posedge clk) disable iff (rst)
    cmd.mul_done |-> $past(cmd.mul_step)) else $error("writeback without step");
endmodule
`default_nettype wire

// File: src/modular_exponentiation.sv
// Top level of the modular exponentiation block.
// Depends on modexp_pkg, modexp_ctrl, modexp_datapath.
// Computes power = base^exponent mod modulus by right-to-left square and
// multiply. One word at a time: after a word is accepted the base is first
// reduced mod modulus (restoring division), then each exponent bit up to the
// highest set bit costs a check state and a squaring on the bit-serial
// multiplier plus, for a set bit, a multiply before the squaring.
// A zero exponent returns 1.
// The modulus register is written through cfg; the user must write it only
// while idle, as the block itself does not enforce this; reset value 1.
`default_nettype none
module modular_exponentiation (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire modexp_pkg::word_t         base,
  input  wire modexp_pkg::word_t         exponent,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output modexp_pkg::word_t              power,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire modexp_pkg::word_t         cfg_data
);
  modexp_pkg::word_t modulus;
  modexp_pkg::dp_cmd_t cmd;
  modexp_pkg::dp_stat_t stat;
  modexp_pkg::word_t acc;

  // Hold the modulus; always accept configuration words.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) modulus <= modexp_pkg::word_t'(1);
    else if (cfg_valid) modulus <= cfg_data;
  end

  modexp_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready,
    .stat, .cmd
  );

  modexp_datapath u_dp (
    .clk, .cmd, .base_in(base), .exp_in(exponent), .mod_in(modulus),
    .stat, .acc_out(acc)
  );

  assign power = acc;
endmodule
`default_nettype wire
